>>> src/pga_pkg.sv
// Shared types and constants for the pixel group averager.
package pga_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 10;
  localparam int GSIZE_W    = 7;
  localparam int LIMIT_W    = 11;
  localparam int MAX_GROUP  = 64;
  localparam int NOTE_CAP   = 1024;
  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port.
  localparam logic REG_GROUP_SIZE = 1'b0;
  localparam logic REG_NOTE_LIMIT = 1'b1;

  // Classification of one queued job, decided by the front end.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               note_valid;
    logic               line_done;
    logic               need_div;
  } pga_ctl_t;

  localparam int CTL_W = $bits(pga_ctl_t);

endpackage

>>> src/pga_queue.sv
// Small first-word-fall-through queue between the front and back ends.
module pga_queue
  import pga_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/pga_front.sv
// Front end: accumulates samples into groups and decides which beats make a result.
module pga_front
  import pga_pkg::*;
#(
  parameter int MAX_GRP = MAX_GROUP,
  parameter int FILL_W  = $clog2(MAX_GRP + 1),
  parameter int SUM_W   = SAMPLE_W + FILL_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [GSIZE_W-1:0]  group_size,
  input  logic [LIMIT_W-1:0]  note_limit,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                line_end,
  output logic                push,
  output pga_ctl_t            push_ctl,
  output logic [SUM_W-1:0]    push_sum,
  output logic [FILL_W-1:0]   push_fill,
  input  logic                queue_full
);

  localparam int CMP_W = (FILL_W > GSIZE_W) ? FILL_W : GSIZE_W;

  logic [SUM_W-1:0]   group_sum;
  logic [FILL_W-1:0]  group_fill;
  logic [LIMIT_W-1:0] notes_done;

  logic [SUM_W-1:0]   sum_next;
  logic [FILL_W-1:0]  fill_next;
  logic [CMP_W-1:0]   eff_group;
  logic [LIMIT_W-1:0] eff_limit;
  logic               accept;
  logic               group_done;
  logic               have_note;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (group_size == '0) begin
      eff_group = CMP_W'(1);
    end else if (CMP_W'(group_size) > CMP_W'(MAX_GRP)) begin
      eff_group = CMP_W'(MAX_GRP);
    end else begin
      eff_group = CMP_W'(group_size);
    end
    if (note_limit > LIMIT_W'(NOTE_CAP)) begin
      eff_limit = LIMIT_W'(NOTE_CAP);
    end else begin
      eff_limit = note_limit;
    end
    sum_next   = group_sum + SUM_W'(sample);
    fill_next  = group_fill + 1'b1;
    group_done = (CMP_W'(fill_next) >= eff_group);
    have_note  = group_done && (notes_done < eff_limit);
  end

  always_comb begin
    push                = accept && (have_note || line_end);
    push_sum            = sum_next;
    push_fill           = fill_next;
    push_ctl.index      = have_note ? notes_done[INDEX_W-1:0] : '0;
    push_ctl.note_valid = have_note;
    push_ctl.line_done  = line_end;
    push_ctl.need_div   = have_note && (notes_done != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum  <= '0;
      group_fill <= '0;
      notes_done <= '0;
    end else if (accept) begin
      if (line_end) begin
        group_sum  <= '0;
        group_fill <= '0;
        notes_done <= '0;
      end else if (group_done) begin
        group_sum  <= '0;
        group_fill <= '0;
        if (have_note) begin
          notes_done <= notes_done + 1'b1;
        end
      end else begin
        group_sum  <= sum_next;
        group_fill <= fill_next;
      end
    end
  end

endmodule

>>> src/pga_back.sv
// Back end: divides a group sum by its fill one quotient bit per cycle and holds the result.
module pga_back
  import pga_pkg::*;
#(
  parameter int FILL_W = 7,
  parameter int SUM_W  = SAMPLE_W + FILL_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_pop,
  input  pga_ctl_t            job_ctl,
  input  logic [SUM_W-1:0]    job_sum,
  input  logic [FILL_W-1:0]   job_fill,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_level,
  output logic [INDEX_W-1:0]  out_index,
  output logic                out_note,
  output logic                out_last
);

  localparam int CNT_W = $clog2(SAMPLE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t             state;
  logic [SAMPLE_W-1:0] quo;
  logic [FILL_W-1:0]  rem;
  logic [FILL_W-1:0]  divisor;
  logic [CNT_W-1:0]   cnt;
  pga_ctl_t           ctl;

  logic [FILL_W:0]    rem_sh;
  logic [FILL_W:0]    rem_sub;
  logic               fits;
  logic               out_free;
  logic               load_out;

  assign job_pop  = (state == ST_IDLE) && job_valid;
  assign out_free = !out_valid || out_ready;
  assign load_out = (state == ST_HOLD) && out_free;

  always_comb begin
    rem_sh  = {rem, quo[SAMPLE_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            ctl     <= job_ctl;
            divisor <= job_fill;
            cnt     <= CNT_W'(SAMPLE_W - 1);
            // The sum is below fill times 2^SAMPLE_W, so its upper part already
            // fits as a partial remainder.
            rem     <= job_sum[SUM_W-1:SAMPLE_W];
            if (job_ctl.need_div) begin
              quo   <= job_sum[SAMPLE_W-1:0];
              state <= ST_DIV;
            end else begin
              quo   <= '0;
              state <= ST_HOLD;
            end
          end
        end
        ST_DIV: begin
          rem <= fits ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
          quo <= {quo[SAMPLE_W-2:0], fits};
          if (cnt == '0) begin
            state <= ST_HOLD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_level <= quo;
            out_index <= ctl.index;
            out_note  <= ctl.note_valid;
            out_last  <= ctl.line_done;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/pixel_group_averager_unit.sv
// Top level of the pixel group averager: front end, job queue and divider back end.
//
//   Channel   Direction  Beat contents
//   s_*       in         tdata[15:0] sample; tlast line_end
//   m_*       out        tdata[15:0] note_level, tdata[25:16] note_index; tuser note_valid;
//                        tlast line_done
//   cfg_*     in         cfg_index 0 group_size, 1 note_limit; written when cfg_wen is high
//
// The front end takes one input beat every cycle while the queue is not full and needs no
// divider, so a line streams in at full rate. Each result goes through a four-entry queue
// to the back end, which pops a note that needs a mean, runs sixteen restoring division
// steps and loads the output once it is free; a note-zero or a line-end-only result is
// popped and loaded with no division. Input stalls only when the queue is full, which
// happens when groups complete faster than the back end drains them for long stretches.
// Reset (rst, synchronous) clears the group state, the queue and the output valid; the
// configuration returns to group_size 1 and note_limit 1024.
module pixel_group_averager_unit
  import pga_pkg::*;
#(
  parameter int MAX_GRP = MAX_GROUP
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_wen,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_data,
  // Input stream.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // [15:0] sample
  input  logic               s_tlast,
  // Output stream.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // [15:0] note_level, [25:16] note_index, rest zero
  output logic               m_tuser,   // [0] note_valid
  output logic               m_tlast
);

  localparam int FILL_W = $clog2(MAX_GRP + 1);
  localparam int SUM_W  = SAMPLE_W + FILL_W;
  localparam int JOB_W  = CTL_W + SUM_W + FILL_W;

  logic [GSIZE_W-1:0] group_size;
  logic [LIMIT_W-1:0] note_limit;

  // Configuration registers; the user must write them only while the block is idle; not enforced here.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GSIZE_W'(1);
      note_limit <= LIMIT_W'(1024);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_GROUP_SIZE: group_size <= cfg_data[GSIZE_W-1:0];
        REG_NOTE_LIMIT: note_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  logic              push;
  pga_ctl_t          push_ctl;
  logic [SUM_W-1:0]  push_sum;
  logic [FILL_W-1:0] push_fill;
  logic              queue_full;

  pga_front #(
    .MAX_GRP (MAX_GRP),
    .FILL_W  (FILL_W),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .note_limit (note_limit),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .sample     (s_tdata),
    .line_end   (s_tlast),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_sum   (push_sum),
    .push_fill  (push_fill),
    .queue_full (queue_full)
  );

  logic             job_valid;
  logic             job_pop;
  logic [JOB_W-1:0] job_word;
  pga_ctl_t         job_ctl;
  logic [SUM_W-1:0] job_sum;
  logic [FILL_W-1:0] job_fill;

  pga_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_sum, push_fill}),
    .full      (queue_full),
    .pop       (job_pop),
    .valid     (job_valid),
    .pop_data  (job_word)
  );

  assign {job_ctl, job_sum, job_fill} = job_word;

  logic [SAMPLE_W-1:0] out_level;
  logic [INDEX_W-1:0]  out_index;

  pga_back #(
    .FILL_W (FILL_W),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_ctl   (job_ctl),
    .job_sum   (job_sum),
    .job_fill  (job_fill),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_level (out_level),
    .out_index (out_index),
    .out_note  (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {6'b0, out_index, out_level};

endmodule

>>> tb/pixel_group_averager_unit_tb.sv
// Self-checking testbench for the pixel group averager unit.
module pixel_group_averager_unit_tb;
  import pga_pkg::*;

  // One expected or observed output beat, field by field.
  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [INDEX_W-1:0]  index;
    logic                has_note;
    logic                done;
  } note_t;

  // Clock period and the settle time used after the last expected beat before
  // any register write. A pixel that yields no beat only touches the front end, so once
  // every expected beat is out nothing is left in the queue or the back end.
  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PIXELS = 90;

  // Tracks the block's group state and configuration, predicts the beats that
  // each accepted pixel causes and checks the output beats against them in order.
  class note_tracker;
    logic [GSIZE_W-1:0] group_size;
    logic [LIMIT_W-1:0] note_limit;
    logic [21:0]        group_sum;
    int unsigned        group_fill;
    int unsigned        notes_done;
    note_t              expected_notes[$];
    int                 mismatches;

    function new();
      group_size = 1;
      note_limit = NOTE_CAP;
      group_sum  = '0;
      group_fill = 0;
      notes_done = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [LIMIT_W-1:0] value);
      if (idx == REG_GROUP_SIZE) begin
        group_size = value[GSIZE_W-1:0];
      end else begin
        note_limit = value;
      end
    endfunction

    function int pending();
      return expected_notes.size();
    endfunction

    // Called once per accepted input beat.
    function void note_pixel(logic [SAMPLE_W-1:0] smp, logic lst);
      int unsigned eff_size;
      int unsigned eff_limit;
      note_t       want;
      // A zero size behaves as one and anything past the maximum is clamped;
      // the note limit is clamped the same way but zero stays zero.
      eff_size  = (group_size == 0) ? 1 : ((group_size > MAX_GROUP) ? MAX_GROUP : group_size);
      eff_limit = (note_limit > NOTE_CAP) ? NOTE_CAP : note_limit;
      want      = '0;
      group_sum  = group_sum + smp;
      group_fill = group_fill + 1;
      // The group closes once the fill reaches or passes the size, so a size
      // lowered mid-group closes it early and the mean divides by the real fill.
      if (group_fill >= eff_size) begin
        if (notes_done < eff_limit) begin
          want.has_note = 1'b1;
          want.index    = notes_done[INDEX_W-1:0];
          want.level    = (notes_done == 0) ? '0 : SAMPLE_W'(group_sum / group_fill);
          notes_done    = notes_done + 1;
        end
        group_sum  = '0;
        group_fill = 0;
      end
      // A line end drops any partial group and restarts the note count.
      if (lst) begin
        group_sum  = '0;
        group_fill = 0;
        notes_done = 0;
      end
      want.done = lst;
      if (want.has_note || lst) begin
        expected_notes.push_back(want);
      end
    endfunction

    // Called once per accepted output beat.
    function void check_result(logic [SAMPLE_W-1:0] level, logic [INDEX_W-1:0] index,
                               logic has_note, logic done);
      note_t want;
      if (expected_notes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected output beat: level %0d index %0d note %0b done %0b",
                   $time, level, index, has_note, done);
        end
        return;
      end
      want = expected_notes.pop_front();
      if (level !== want.level || index !== want.index ||
          has_note !== want.has_note || done !== want.done) begin
        mismatches++;
        if (mismatches <= 10) begin
          // Fields are listed as level/index/note/done.
          $display("%0t: mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                   $time, want.level, want.index, want.has_note, want.done,
                   level, index, has_note, done);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic               cfg_index = REG_GROUP_SIZE;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata = '0;   // [15:0] sample
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;        // [15:0] note_level, [25:16] note_index
  logic               m_tuser;        // [0] note_valid
  logic               m_tlast;

  note_tracker tracker;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          pixels_sent = 0;

  pixel_group_averager_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #(CLK_PERIOD * 1000000);
    $display("TEST FAILED");
    $finish;
  end

  // The receiver drops tready at random, at the rate of the current mode.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both handshakes are observed at the same edge. An input beat is always
  // predicted before an output beat of the same edge is checked, although the
  // block's latency keeps a pixel's own beat from coming out that early.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tracker.note_pixel(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        tracker.check_result(m_tdata[SAMPLE_W-1:0], m_tdata[16 +: INDEX_W], m_tuser, m_tlast);
      end
    end
  end

  // Sends one pixel. tvalid stays high after the beat so back-to-back pixels
  // never see a low and a high assigned in the same step; an idle gap lowers it.
  task automatic send_pixel(input logic [15:0] smp, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // Holds the sender off until every expected beat has come out, then lets the
  // front end settle so registers can be written safely.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the block must be idle.
  task automatic program_regs(input logic [LIMIT_W-1:0] gs_word,
                              input logic [LIMIT_W-1:0] nl_word);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_GROUP_SIZE;
    cfg_data  <= gs_word;
    @(posedge clk);
    tracker.write_reg(REG_GROUP_SIZE, gs_word);
    cfg_index <= REG_NOTE_LIMIT;
    cfg_data  <= nl_word;
    @(posedge clk);
    tracker.write_reg(REG_NOTE_LIMIT, nl_word);
    cfg_wen <= 1'b0;
  endtask

  // Samples lean toward black and full white now and then.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random phases: each picks a setting, then streams a few lines. Most lines
  // span whole groups plus a remainder; the last line of a phase is sometimes
  // left open so the next setting lands in the middle of a group. Sending stops
  // as soon as the pixel budget is spent, which may also leave a line open.
  task automatic run_phases(input int target);
    int unsigned gs;
    int unsigned nl;
    int unsigned eff;
    int          lines;
    int          len;
    logic        open_line;
    while (pixels_sent < target) begin
      case ($urandom_range(15))
        0: gs = 0;
        1: gs = MAX_GROUP;
        2: gs = $urandom_range(MAX_GROUP + 1, 127);
        3: gs = $urandom_range(9, MAX_GROUP - 1);
        default: gs = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
        0: nl = 0;
        1: nl = 1;
        2: nl = NOTE_CAP;
        3: nl = $urandom_range(NOTE_CAP + 1, 2047);
        default: nl = $urandom_range(2, 12);
      endcase
      eff = (gs == 0) ? 1 : ((gs > MAX_GROUP) ? MAX_GROUP : gs);
      settle();
      // Upper bits of the group size word are not part of the register.
      program_regs({4'($urandom), 7'(gs)}, 11'(nl));
      lines = $urandom_range(1, 4);
      for (int l = 0; l < lines && pixels_sent < target; l++) begin
        if ($urandom_range(7) == 0) begin
          len = $urandom_range(1, eff);
        end else begin
          len = eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
        end
        open_line = (l == lines - 1) && ($urandom_range(3) == 0);
        for (int p = 0; p < len && pixels_sent < target; p++) begin
          send_pixel(pick_sample(), !open_line && (p == len - 1));
        end
      end
    end
  endtask

  initial begin
    int base;
    int len;
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 67;

    // Reset setting, one pixel per note: note zero reads zero, the others carry
    // the pixel itself, full white included.
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h8001, 1'b1);

    // Groups of three, two notes per line: the third group is dropped and the
    // line ends on a partial group, so its beat carries no note.
    settle();
    program_regs(11'd3, 11'd2);
    for (int i = 0; i < 10; i++) begin
      send_pixel(16'hFFFF - 16'(i), i == 9);
    end

    // Zero group size acts as one, zero note limit gives only the line end.
    settle();
    program_regs(11'd0, 11'd0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h1234, 1'b1);

    // Group size lowered mid-group: three pixels are open when the size drops
    // to two, so the next pixel closes the group and the mean divides by four.
    settle();
    program_regs(11'd6, 11'(NOTE_CAP));
    for (int i = 0; i < 9; i++) begin
      send_pixel((i % 2) ? 16'h0001 : 16'hFFFF, 1'b0);
    end
    settle();
    program_regs(11'd2, 11'(NOTE_CAP));
    send_pixel(16'h7FFF, 1'b1);

    // Random part in three idling modes.
    base = pixels_sent;
    run_phases(base + RANDOM_PIXELS / 3);
    send_idle_pct = 67;
    recv_idle_pct = 11;
    run_phases(base + 2 * RANDOM_PIXELS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phases(base + RANDOM_PIXELS);

    // One long line at one pixel per note runs the note index to its top and
    // past the limit, with the limit register written above the maximum.
    settle();
    program_regs(11'd1, 11'($urandom_range(NOTE_CAP + 1, 2047)));
    len = $urandom_range(NOTE_CAP + 2, NOTE_CAP + 10);
    for (int p = 0; p < len; p++) begin
      send_pixel(pick_sample(), p == len - 1);
    end

    settle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
